// ===== rtl/wait_for_graph_cycle_detector_core_assert.svh =====
// Assertion macros for the wait-for graph cycle detector.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef WAIT_FOR_GRAPH_CYCLE_DETECTOR_CORE_ASSERT_SVH
`define WAIT_FOR_GRAPH_CYCLE_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define WFG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define WFG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`else
`define WFG_ASSERT(lbl, prop)
`define WFG_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== rtl/wfg_pkg.sv =====
package wfg_pkg;

  localparam int NUM_THREADS = 64;
  localparam int TID_W       = $clog2(NUM_THREADS);
  localparam int CNT_W       = $clog2(NUM_THREADS + 1);

  // Field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int THR_W   = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DETECT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_WR,
    S_DET_ROOT,
    S_DET_SCAN,
    S_DET_POP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic [TID_W-1:0]       addr;
    logic [NUM_THREADS-1:0] wdata;
  } adj_req_t;

  typedef struct packed {
    logic [TID_W-1:0] vtx;
    logic [CNT_W-1:0] pos;
  } stk_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [TID_W-1:0] addr;
    stk_entry_t       wdata;
  } stk_req_t;

endpackage

// ===== rtl/wfg_adj_mem.sv =====
module wfg_adj_mem import wfg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  adj_req_t               req_i,
  output logic [NUM_THREADS-1:0] row_o
);

  logic [NUM_THREADS-1:0] mem_q [NUM_THREADS];
  logic [NUM_THREADS-1:0] rdata_q;
  logic [NUM_THREADS-1:0] vld_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  // Row valid bits: a row never written reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign row_o = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/wfg_stk_mem.sv =====
module wfg_stk_mem import wfg_pkg::*; (
  input  logic       clk_i,
  input  stk_req_t   req_i,
  output stk_entry_t rdata_o
);

  stk_entry_t mem_q [NUM_THREADS];
  stk_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wfg_ffs.sv =====
module wfg_ffs import wfg_pkg::*; (
  input  logic [NUM_THREADS-1:0] vec_i,
  output logic                   found_o,
  output logic [TID_W-1:0]       idx_o
);

  logic [NUM_THREADS-1:0] lowest;

  // Isolate the lowest set bit, then encode it
  assign lowest  = vec_i & (~vec_i + NUM_THREADS'(1));
  assign found_o = |vec_i;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < NUM_THREADS; i++) begin
      idx_o = idx_o | (lowest[i] ? TID_W'(i) : '0);
    end
  end

endmodule

// ===== rtl/wait_for_graph_cycle_detector_core.sv =====
// Wait-for graph cycle detector. The block holds a directed graph over
// NUM_THREADS threads as an adjacency bit matrix (row = waiting thread, bit =
// thread waited on), empty after reset. Add and remove commands set or clear
// one edge; an edge command naming a thread at or above NUM_THREADS, or the
// unused command code, changes nothing. A detect command runs a depth-first
// search from every unvisited thread in rising order and reports whether an
// edge closes a cycle (a self loop counts); it stops at the first such edge.
// Every command gives exactly one result, echoing the command code.
// Steps, from the transfer of a command to the load of its result register:
// an edge command writes the row and then loads the result (the row is read
// at the transfer edge); an unused command loads its result directly. A
// detect runs a root search per root plus a final one, a scan step per push
// below a root and per pop, a stack reload per pop below a root, and the
// result load; a cycle ends the search at the closing edge. The idle state
// follows the result load before the next transfer. A single find-first
// unit, one adjacency row read and one stack read per cycle set the pace of
// the search. The input is not ready while a command is at work.
// A finished result waits in the output register and the next command is
// taken meanwhile. The adjacency matrix is cleared by per-row valid bits,
// so no clearing pass follows reset.
`include "wait_for_graph_cycle_detector_core_assert.svh"

module wait_for_graph_cycle_detector_core import wfg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [THR_W-1:0] src_thread_i,
  input  logic [THR_W-1:0] dst_thread_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CMD_W-1:0] reply_kind_o,
  output logic             cycle_found_o
);

  state_e state_q, state_d;

  // Command held for the duration of its work
  logic [CMD_W-1:0] cmd_q;
  logic [THR_W-1:0] src_q;
  logic [THR_W-1:0] dst_q;

  // Search state
  logic [NUM_THREADS-1:0] visited_q;
  logic [NUM_THREADS-1:0] onpath_q;
  logic [TID_W-1:0]       top_v_q;
  logic [CNT_W-1:0]       top_pos_q;
  logic [CNT_W-1:0]       below_q;   // entries held in the stack memory
  logic                   found_q;

  // Result register
  logic             out_valid_q;
  logic [CMD_W-1:0] out_kind_q;
  logic             out_found_q;

  adj_req_t               adj_req;
  logic [NUM_THREADS-1:0] adj_row;
  stk_req_t               stk_req;
  stk_entry_t             stk_rdata;

  logic                   ffs_found;
  logic [TID_W-1:0]       ffs_idx;
  logic [NUM_THREADS-1:0] ffs_vec;
  logic [NUM_THREADS-1:0] cand;
  logic [NUM_THREADS-1:0] dst_bit;
  logic                   hit_onpath;
  logic                   accept;
  logic                   in_range;
  logic                   out_load;
  logic                   do_root;
  logic                   do_push;
  logic                   do_pop;
  logic                   do_close;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = ({26'd0, src_thread_i} < 32'(NUM_THREADS)) &&
                    ({26'd0, dst_thread_i} < 32'(NUM_THREADS));

  // Candidate neighbours of the top vertex: not yet scanned, and either
  // unvisited or on the current path. Finished vertices are skipped, as a
  // finished vertex neither closes a cycle nor gets pushed.
  assign cand = adj_row & ~(visited_q & ~onpath_q) &
                ({NUM_THREADS{1'b1}} << top_pos_q);

  // Share one find-first unit between root search and neighbour scan
  assign ffs_vec = (state_q == S_DET_ROOT) ? ~visited_q : cand;

  wfg_ffs u_ffs (
    .vec_i   (ffs_vec),
    .found_o (ffs_found),
    .idx_o   (ffs_idx)
  );

  assign hit_onpath = onpath_q[ffs_idx];
  assign dst_bit    = NUM_THREADS'(1) << TID_W'(dst_q);

  wfg_adj_mem u_adj_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (adj_req),
    .row_o  (adj_row)
  );

  wfg_stk_mem u_stk_mem (
    .clk_i   (clk_i),
    .req_i   (stk_req),
    .rdata_o (stk_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_DETECT) begin
            state_d = S_DET_ROOT;
          end else if ((cmd_i == CMD_ADD || cmd_i == CMD_REMOVE) && in_range) begin
            state_d = S_EDGE_WR;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_EDGE_WR: state_d = S_DONE;
      S_DET_ROOT: begin
        state_d = ffs_found ? S_DET_SCAN : S_DONE;
      end
      S_DET_SCAN: begin
        if (ffs_found) begin
          state_d = hit_onpath ? S_DONE : S_DET_SCAN;
        end else if (below_q == '0) begin
          state_d = S_DET_ROOT;
        end else begin
          state_d = S_DET_POP;
        end
      end
      S_DET_POP: state_d = S_DET_SCAN;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory requests and datapath strobes
  always_comb begin
    adj_req        = '0;
    stk_req        = '0;
    in_ready_o     = 1'b0;
    out_load       = 1'b0;
    do_root        = 1'b0;
    do_push        = 1'b0;
    do_pop         = 1'b0;
    do_close       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        adj_req.rd_en = in_valid_i && (cmd_i == CMD_ADD || cmd_i == CMD_REMOVE) && in_range;
        adj_req.addr  = TID_W'(src_thread_i);
      end
      S_EDGE_WR: begin
        adj_req.wr_en = 1'b1;
        adj_req.addr  = TID_W'(src_q);
        adj_req.wdata = (cmd_q == CMD_ADD) ? (adj_row | dst_bit) : (adj_row & ~dst_bit);
      end
      S_DET_ROOT: begin
        do_root       = ffs_found;
        adj_req.rd_en = ffs_found;
        adj_req.addr  = ffs_idx;
      end
      S_DET_SCAN: begin
        do_close = ffs_found && hit_onpath;
        do_push  = ffs_found && !hit_onpath;
        do_pop   = !ffs_found;
        // Park the top vertex with its resume position, fetch the new row
        adj_req.rd_en     = do_push;
        adj_req.addr      = ffs_idx;
        stk_req.wr_en     = do_push;
        stk_req.wdata.vtx = top_v_q;
        stk_req.wdata.pos = CNT_W'(ffs_idx) + CNT_W'(1);
        stk_req.rd_en     = !ffs_found && (below_q != '0);
        stk_req.addr      = do_push ? below_q[TID_W-1:0] : TID_W'(below_q - CNT_W'(1));
      end
      S_DET_POP: begin
        adj_req.rd_en = 1'b1;
        adj_req.addr  = stk_rdata.vtx;
      end
      S_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      visited_q   <= '0;
      onpath_q    <= '0;
      below_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        found_q <= 1'b0;
        if (cmd_i == CMD_DETECT) begin
          visited_q <= '0;
          onpath_q  <= '0;
          below_q   <= '0;
        end
      end
      if (do_root || do_push) begin
        visited_q[ffs_idx] <= 1'b1;
        onpath_q[ffs_idx]  <= 1'b1;
      end
      if (do_push) begin
        below_q <= below_q + CNT_W'(1);
      end
      if (do_pop) begin
        onpath_q[top_v_q] <= 1'b0;
        if (below_q != '0) begin
          below_q <= below_q - CNT_W'(1);
        end
      end
      if (do_close) begin
        found_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      src_q <= src_thread_i;
      dst_q <= dst_thread_i;
    end
    if (do_root || do_push) begin
      top_v_q   <= ffs_idx;
      top_pos_q <= '0;
    end
    if (state_q == S_DET_POP) begin
      top_v_q   <= stk_rdata.vtx;
      top_pos_q <= stk_rdata.pos;
    end
    if (out_load) begin
      out_kind_q  <= cmd_q;
      out_found_q <= found_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reply_kind_o  = out_kind_q;
  assign cycle_found_o = out_found_q;

  `WFG_ASSERT(a_path_in_visited, ((onpath_q & ~visited_q) == '0))
  `WFG_ASSERT_IMP(a_top_on_path, state_q == S_DET_SCAN, onpath_q[top_v_q])
  `WFG_ASSERT_IMP(a_cycle_only_detect, out_valid_q && out_found_q, out_kind_q == CMD_DETECT)
  `WFG_ASSERT(a_push_depth, (do_push |=> (below_q == $past(below_q) + CNT_W'(1))))

endmodule
